// ===== hdl/aat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_pkg
// Shared constants for the transformed bounding box block: matrix element
// width, configuration register layout, reset values and pipeline depth.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int ELEM_W     = 32;
  localparam int CFG_W      = 64;
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int N_AXES     = 3;
  localparam int NUM_ELEMS  = 12;
  localparam int PIPE_DEPTH = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PAIR_A = 3'd0;
  localparam cfg_idx_t REG_PAIR_B = 3'd1;
  localparam cfg_idx_t REG_PAIR_C = 3'd2;
  localparam cfg_idx_t REG_PAIR_D = 3'd3;
  localparam cfg_idx_t REG_PAIR_E = 3'd4;
  localparam cfg_idx_t REG_PAIR_F = 3'd5;

  localparam logic [CFG_W-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0001_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000
  };

endpackage

// ===== hdl/aat_term_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_term_unit
// Multiplies the low and high box coordinate by one matrix element and
// registers the smaller and the larger of the two products.
// ----------------------------------------------------------------------------
module aat_term_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                            clk_i,
  input  logic                                            en_i,
  input  logic signed [COORD_WIDTH-1:0]                   lo_i,
  input  logic signed [COORD_WIDTH-1:0]                   hi_i,
  input  logic signed [aat_pkg::ELEM_W-1:0]               elem_i,
  output logic signed [COORD_WIDTH+aat_pkg::ELEM_W-1:0]   min_o,
  output logic signed [COORD_WIDTH+aat_pkg::ELEM_W-1:0]   max_o
);

  localparam int PROD_W = COORD_WIDTH + aat_pkg::ELEM_W;

  logic signed [PROD_W-1:0] prod_lo_d, prod_lo_q;
  logic signed [PROD_W-1:0] prod_hi_d, prod_hi_q;
  logic signed [PROD_W-1:0] min_d, min_q;
  logic signed [PROD_W-1:0] max_d, max_q;

  always_comb begin
    prod_lo_d = PROD_W'(lo_i) * PROD_W'(elem_i);
    prod_hi_d = PROD_W'(hi_i) * PROD_W'(elem_i);
    if (prod_lo_q < prod_hi_q) begin
      min_d = prod_lo_q;
      max_d = prod_hi_q;
    end else begin
      min_d = prod_hi_q;
      max_d = prod_lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      min_q     <= min_d;
      max_q     <= max_d;
    end
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

// ===== hdl/aat_axis_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_axis_lane
// One world axis: per-row extreme products, a two-level sum with the
// translation, then floor shift and saturation of the lower and upper bound.
// ----------------------------------------------------------------------------
module aat_axis_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [COORD_WIDTH-1:0]      lo_i    [aat_pkg::N_AXES],
  input  logic signed [COORD_WIDTH-1:0]      hi_i    [aat_pkg::N_AXES],
  input  logic signed [aat_pkg::ELEM_W-1:0]  elem_i  [aat_pkg::N_AXES],
  input  logic signed [aat_pkg::ELEM_W-1:0]  trans_i,
  output logic signed [COORD_WIDTH-1:0]      min_o,
  output logic signed [COORD_WIDTH-1:0]      max_o,
  output logic                               ovf_o
);

  localparam int PROD_W  = COORD_WIDTH + aat_pkg::ELEM_W;
  localparam int TRANS_W = aat_pkg::ELEM_W + FRAC_BITS;
  localparam int SUM_W   = ((PROD_W > TRANS_W) ? PROD_W : TRANS_W) + 2;
  localparam int SH_W    = SUM_W - FRAC_BITS;

  logic signed [PROD_W-1:0]      ext     [2][aat_pkg::N_AXES];
  logic signed [SUM_W-1:0]       trans_ext;
  logic signed [SUM_W-1:0]       part_a_d [2], part_a_q [2];
  logic signed [SUM_W-1:0]       part_b_d [2], part_b_q [2];
  logic signed [SUM_W-1:0]       sum_d    [2], sum_q    [2];
  logic signed [COORD_WIDTH-1:0] bound_d  [2], bound_q  [2];
  logic                          sat      [2];
  logic                          ovf_d, ovf_q;

  for (genvar i = 0; i < aat_pkg::N_AXES; i++) begin : g_term
    aat_term_unit #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_term (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .lo_i   (lo_i[i]),
      .hi_i   (hi_i[i]),
      .elem_i (elem_i[i]),
      .min_o  (ext[0][i]),
      .max_o  (ext[1][i])
    );
  end

  assign trans_ext = SUM_W'(trans_i) <<< FRAC_BITS;

  for (genvar b = 0; b < 2; b++) begin : g_bound
    logic [SH_W-1:0]          shifted;
    logic [SH_W-COORD_WIDTH:0] top_bits;

    assign part_a_d[b] = SUM_W'(ext[b][0]) + SUM_W'(ext[b][1]);
    assign part_b_d[b] = SUM_W'(ext[b][2]) + trans_ext;
    assign sum_d[b]    = part_a_q[b] + part_b_q[b];

    assign shifted  = sum_q[b][SUM_W-1:FRAC_BITS];
    assign top_bits = shifted[SH_W-1:COORD_WIDTH-1];
    assign sat[b]   = !((&top_bits) || !(|top_bits));

    always_comb begin
      if (!sat[b]) begin
        bound_d[b] = shifted[COORD_WIDTH-1:0];
      end else if (shifted[SH_W-1]) begin
        bound_d[b] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        bound_d[b] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        part_a_q[b] <= part_a_d[b];
        part_b_q[b] <= part_b_d[b];
        sum_q[b]    <= sum_d[b];
        bound_q[b]  <= bound_d[b];
      end
    end
  end

  assign ovf_d = sat[0] || sat[1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q <= ovf_d;
    end
  end

  assign min_o = bound_q[0];
  assign max_o = bound_q[1];
  assign ovf_o = ovf_q;

endmodule

// ===== hdl/aabb_affine_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform
// World-space bounds of a local box under a row-vector affine matrix held in
// six 64-bit configuration registers of two Q16.16 elements each.
//
//   Channel  Direction  Handshake                    Content
//   s_axis   in         s_axis_tvalid/tready         box min x,y,z, max x,y,z
//   m_axis   out        m_axis_tvalid/tready         world min x,y,z, max x,y,z;
//                                                    tuser: range overflow
//   cfg      in         cfg_valid_i/cfg_ready_o      register index, 64-bit data
//
// One item per clock cycle while the output is not stalled; the path runs through the multiply,
// extreme-select, two adder and saturation stages.
// Reset clears the valid bits and loads the matrix with its reset values.
// A stall at the output holds every stage; nothing is dropped or repeated.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module aabb_affine_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int TDATA_W    = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [TDATA_W-1:0]              s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
  output logic [TDATA_W-1:0]              m_axis_tdata,
  // range_overflow
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  aat_pkg::cfg_idx_t               cfg_index_i,
  input  logic [aat_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int EW = aat_pkg::ELEM_W;

  logic [aat_pkg::CFG_W-1:0]       mat_d [aat_pkg::NUM_REGS];
  logic [aat_pkg::CFG_W-1:0]       mat_q [aat_pkg::NUM_REGS];
  logic signed [EW-1:0]            elem  [aat_pkg::NUM_ELEMS];
  logic [aat_pkg::PIPE_DEPTH-1:0]  valid_d, valid_q;
  logic                            en;
  logic signed [COORD_WIDTH-1:0]   box_lo [aat_pkg::N_AXES];
  logic signed [COORD_WIDTH-1:0]   box_hi [aat_pkg::N_AXES];
  logic signed [COORD_WIDTH-1:0]   world_min [aat_pkg::N_AXES];
  logic signed [COORD_WIDTH-1:0]   world_max [aat_pkg::N_AXES];
  logic [aat_pkg::N_AXES-1:0]      lane_ovf;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mat_d = mat_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        aat_pkg::REG_PAIR_A: mat_d[0] = cfg_data_i;
        aat_pkg::REG_PAIR_B: mat_d[1] = cfg_data_i;
        aat_pkg::REG_PAIR_C: mat_d[2] = cfg_data_i;
        aat_pkg::REG_PAIR_D: mat_d[3] = cfg_data_i;
        aat_pkg::REG_PAIR_E: mat_d[4] = cfg_data_i;
        aat_pkg::REG_PAIR_F: mat_d[5] = cfg_data_i;
        default: mat_d = mat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= aat_pkg::MAT_RESET;
    end else begin
      mat_q <= mat_d;
    end
  end

  // Even elements sit in the high word of a register, odd ones in the low.
  for (genvar k = 0; k < aat_pkg::NUM_ELEMS; k++) begin : g_elem
    if (k % 2 == 0) begin : g_high
      assign elem[k] = mat_q[k / 2][aat_pkg::CFG_W-1:EW];
    end else begin : g_low
      assign elem[k] = mat_q[k / 2][EW-1:0];
    end
  end

  // Pipeline control.
  assign en            = !valid_q[aat_pkg::PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign valid_d       = {valid_q[aat_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // Datapath lanes, one per world axis.
  for (genvar i = 0; i < aat_pkg::N_AXES; i++) begin : g_in
    assign box_lo[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    assign box_hi[i] = s_axis_tdata[(i+aat_pkg::N_AXES)*COORD_WIDTH +: COORD_WIDTH];
  end

  for (genvar c = 0; c < aat_pkg::N_AXES; c++) begin : g_lane
    logic signed [EW-1:0] col [aat_pkg::N_AXES];

    for (genvar r = 0; r < aat_pkg::N_AXES; r++) begin : g_col
      assign col[r] = elem[r*aat_pkg::N_AXES + c];
    end

    aat_axis_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .lo_i    (box_lo),
      .hi_i    (box_hi),
      .elem_i  (col),
      .trans_i (elem[aat_pkg::N_AXES*aat_pkg::N_AXES + c]),
      .min_o   (world_min[c]),
      .max_o   (world_max[c]),
      .ovf_o   (lane_ovf[c])
    );
  end

  assign m_axis_tvalid = valid_q[aat_pkg::PIPE_DEPTH-1];

  always_comb begin
    m_axis_tdata = '0;
    for (int c = 0; c < aat_pkg::N_AXES; c++) begin
      m_axis_tdata[c*COORD_WIDTH +: COORD_WIDTH] = world_min[c];
      m_axis_tdata[(c+aat_pkg::N_AXES)*COORD_WIDTH +: COORD_WIDTH] = world_max[c];
    end
    m_axis_tuser = |lane_ovf;
  end

  // The lower bound of an axis can never exceed its upper bound.
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(world_min[0]) <= $signed(world_max[0])) &&
      ($signed(world_min[1]) <= $signed(world_max[1])) &&
      ($signed(world_min[2]) <= $signed(world_max[2])))
    else $error("world bounds out of order");

  // An accepted item occupies the first stage in the next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted item missing from first stage");

  // A held pipeline keeps every valid bit in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("valid bits moved during a stall");

  // A stage only fills from the stage before it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !valid_q[aat_pkg::PIPE_DEPTH-2]) |=> !m_axis_tvalid)
    else $error("output valid without a preceding item");

endmodule
